// ===== hw/rtl/cht_pkg.sv =====
`default_nettype none
package cht_pkg;

  // request kinds
  localparam logic [2:0] KIND_ADD      = 3'd0;
  localparam logic [2:0] KIND_GET      = 3'd1;
  localparam logic [2:0] KIND_GET_NEXT = 3'd2;
  localparam logic [2:0] KIND_REM_KEY  = 3'd3;
  localparam logic [2:0] KIND_REM_BOTH = 3'd4;

  // match modes of a chain walk
  typedef enum logic [1:0] {
    MATCH_KEY  = 2'd0,
    MATCH_TAG  = 2'd1,
    MATCH_BOTH = 2'd2
  } match_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_HEAD,
    ST_HEAD_WAIT,
    ST_NODE_RD,
    ST_NODE_WAIT,
    ST_NODE_CHK,
    ST_ADD_WR,
    ST_UNLINK,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic   load;       // capture request word
    logic   div_step;   // one modulo iteration
    logic   head_rd;    // present bucket address to head store
    logic   node_rd;    // present current node to node store
    logic   node_adv;   // follow link
    logic   tag_to_key; // switch from tag walk to key walk from link
    logic   add_wr;     // write node and head
    logic   unlink;     // unlink matched node
    logic   set_hit;    // record matched node as result
    logic   out_load;   // load result register
    match_t mode;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic cur_nil;     // current node is the empty marker
    logic budget_zero;
    logic hit;
    logic slot_ok;
  } sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/chained_hash_table_engine.sv =====
`default_nettype none
// An unused kind goes from the modulo straight to the result; add writes the node
// and head after the head read; a walk visits nodes until a hit (a removal then
// unlinks it), at most NODE_SLOTS nodes. A stalled result holds the engine in ST_DONE.
// Words are taken one at a time, the next in the cycle after the result is
// loaded; pace set by the 32-step bit-serial modulo and the node store read per node.
// Reset: rst_n synchronous, active low; clears bucket valid bits (all chains
// empty) and sets bucket_count to MAX_BUCKETS (at most 511). Node store is not cleared.
module chained_hash_table_engine #(
  parameter int MAX_BUCKETS = 256,
  parameter int NODE_SLOTS  = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // kind[2:0], key[34:3], tag[66:35], slot[74:67], zero[79:75]
  input  wire logic [79:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // found[0], result_tag[32:1], result_slot[40:33], zero[47:41]
  output logic [47:0]      out_tdata
);
  cht_pkg::cmd_t cmd;
  cht_pkg::sts_t sts;
  logic r_found;
  logic [31:0] r_tag;
  logic [7:0] r_slot;
  logic out_busy;

  assign out_busy = out_tvalid && !out_tready;

  cht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .req_valid(in_tvalid), .req_kind(in_tdata[2:0]),
    .req_ready(in_tready), .out_busy(out_busy), .sts(sts), .cmd(cmd));

  cht_datapath #(.MAX_BUCKETS(MAX_BUCKETS), .NODE_SLOTS(NODE_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req_key(in_tdata[34:3]), .req_tag(in_tdata[66:35]),
    .req_slot(in_tdata[74:67]), .cmd(cmd), .sts(sts),
    .res_found(r_found), .res_tag(r_tag), .res_slot(r_slot));

  // output register
  logic out_valid_r;
  logic [47:0] out_data_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.out_load) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data_r <= {7'd0, r_slot, r_tag, r_found};
  end
  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;

`ifndef ASSERT_OFF
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_busy) else $error("result overwritten");
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.add_wr, cmd.unlink, cmd.set_hit, cmd.node_adv}))
    else $error("conflicting commands");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second word taken");
`endif
endmodule
`default_nettype wire

// ===== hw/rtl/cht_ram.sv =====
`default_nettype none
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/cht_ctrl.sv =====
`default_nettype none
module cht_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           req_valid,
  input  wire logic [2:0]     req_kind,
  output logic                req_ready,
  input  wire logic           out_busy,
  input  wire cht_pkg::sts_t  sts,
  output cht_pkg::cmd_t       cmd
);
  cht_pkg::state_t state_r, state_nxt;
  logic [2:0] kind_r;
  logic       phase_r, phase_nxt; // get-next: 0 tag walk, 1 key walk

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cht_pkg::ST_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cht_pkg::ST_IDLE && req_valid) kind_r <= req_kind;
  end

  assign req_ready = (state_r == cht_pkg::ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      cht_pkg::ST_IDLE: if (req_valid) begin
        state_nxt = cht_pkg::ST_DIV;
        phase_nxt = 1'b0;
      end
      cht_pkg::ST_DIV: if (sts.div_done) begin
        if (kind_r > cht_pkg::KIND_REM_BOTH) state_nxt = cht_pkg::ST_DONE;
        else state_nxt = cht_pkg::ST_HEAD;
      end
      cht_pkg::ST_HEAD: state_nxt = cht_pkg::ST_HEAD_WAIT;
      cht_pkg::ST_HEAD_WAIT:
        state_nxt = (kind_r == cht_pkg::KIND_ADD) ? cht_pkg::ST_ADD_WR
                                                  : cht_pkg::ST_NODE_RD;
      cht_pkg::ST_NODE_RD: begin
        if (sts.cur_nil || sts.budget_zero) state_nxt = cht_pkg::ST_DONE;
        else state_nxt = cht_pkg::ST_NODE_WAIT;
      end
      cht_pkg::ST_NODE_WAIT: state_nxt = cht_pkg::ST_NODE_CHK;
      cht_pkg::ST_NODE_CHK: begin
        if (!sts.hit) state_nxt = cht_pkg::ST_NODE_RD;
        else if (kind_r == cht_pkg::KIND_GET_NEXT && !phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = cht_pkg::ST_NODE_RD;
        end else if (kind_r == cht_pkg::KIND_REM_KEY || kind_r == cht_pkg::KIND_REM_BOTH)
          state_nxt = cht_pkg::ST_UNLINK;
        else state_nxt = cht_pkg::ST_DONE;
      end
      cht_pkg::ST_ADD_WR: state_nxt = cht_pkg::ST_DONE;
      cht_pkg::ST_UNLINK: state_nxt = cht_pkg::ST_DONE;
      cht_pkg::ST_DONE: if (!out_busy) state_nxt = cht_pkg::ST_IDLE;
      default: state_nxt = cht_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    cmd.mode = cht_pkg::MATCH_KEY;
    if (kind_r == cht_pkg::KIND_REM_BOTH) cmd.mode = cht_pkg::MATCH_BOTH;
    else if (kind_r == cht_pkg::KIND_GET_NEXT && !phase_r) cmd.mode = cht_pkg::MATCH_TAG;
    unique case (state_r)
      cht_pkg::ST_IDLE:      cmd.load = req_valid;
      cht_pkg::ST_DIV:       cmd.div_step = 1'b1;
      cht_pkg::ST_HEAD:      cmd.head_rd = 1'b1;
      cht_pkg::ST_HEAD_WAIT: ;
      cht_pkg::ST_NODE_RD:   cmd.node_rd = 1'b1;
      cht_pkg::ST_NODE_WAIT: cmd.node_rd = 1'b1;
      cht_pkg::ST_NODE_CHK: begin
        cmd.node_rd = 1'b1;
        if (!sts.hit) cmd.node_adv = 1'b1;
        else if (kind_r == cht_pkg::KIND_GET_NEXT && !phase_r) cmd.tag_to_key = 1'b1;
        else cmd.set_hit = 1'b1;
      end
      cht_pkg::ST_ADD_WR:    cmd.add_wr = sts.slot_ok;
      cht_pkg::ST_UNLINK:    cmd.unlink = 1'b1;
      cht_pkg::ST_DONE:      cmd.out_load = !out_busy;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/cht_datapath.sv =====
`default_nettype none
module cht_datapath #(
  parameter int MAX_BUCKETS = 256,
  parameter int NODE_SLOTS  = 256
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [8:0]    cfg_wdata,
  input  wire logic [31:0]   req_key,
  input  wire logic [31:0]   req_tag,
  input  wire logic [7:0]    req_slot,
  input  wire cht_pkg::cmd_t cmd,
  output cht_pkg::sts_t      sts,
  output logic               res_found,
  output logic [31:0]        res_tag,
  output logic [7:0]         res_slot
);
  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int NW = $clog2(NODE_SLOTS);   // node index bits
  localparam int PW = NW + 1;               // with empty marker
  localparam int CW = $clog2(MAX_BUCKETS + 1);
  localparam int RW = CW + 1;
  localparam logic [PW-1:0] NIL = PW'(NODE_SLOTS);
  localparam logic [8:0] MAXB9 = 9'((MAX_BUCKETS > 511) ? 511 : MAX_BUCKETS);

  // bucket count register, clamped
  logic [8:0] bcount_r;
  always_ff @(posedge clk) begin
    if (!rst_n) bcount_r <= MAXB9;
    else if (cfg_we) begin
      if (cfg_wdata == 9'd0) bcount_r <= 9'd1;
      else if (cfg_wdata > MAXB9) bcount_r <= MAXB9;
      else bcount_r <= cfg_wdata;
    end
  end

  // request word
  logic [31:0] key_r, tag_r;
  logic [7:0]  slot_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= req_key;
      tag_r <= req_tag;
      slot_r <= req_slot;
    end
  end

  // restoring modulo, one quotient bit a cycle
  logic [31:0] dq_r;
  logic [RW-1:0] rem_r;
  logic [5:0] dcnt_r;
  logic [RW-1:0] trial;
  logic [RW:0] trial_sub;
  assign trial = {rem_r[RW-2:0], dq_r[31]};
  assign trial_sub = {1'b0, trial} - {1'b0, RW'(bcount_r)};
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dq_r <= req_key;
      rem_r <= '0;
      dcnt_r <= '0;
    end else if (cmd.div_step && dcnt_r != 6'd32) begin
      dq_r <= {dq_r[30:0], 1'b0};
      rem_r <= trial_sub[RW] ? trial : trial_sub[RW-1:0];
      dcnt_r <= dcnt_r + 6'd1;
    end
  end
  logic [BW-1:0] bucket;
  assign bucket = BW'(rem_r);

  // head store with per-bucket valid bits
  logic [MAX_BUCKETS-1:0] hvalid_r;
  logic head_we;
  logic [PW-1:0] head_wdata, head_q, head_cur;
  logic hv_q_r;
  cht_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_heads (
    .clk(clk), .we(head_we), .waddr(bucket), .wdata(head_wdata),
    .raddr(bucket), .rdata(head_q));
  always_ff @(posedge clk) begin
    if (!rst_n) hvalid_r <= '0;
    else if (head_we) hvalid_r[bucket] <= 1'b1;
  end
  always_ff @(posedge clk) hv_q_r <= hvalid_r[bucket];
  assign head_cur = hv_q_r ? head_q : NIL;

  // node stores
  logic [PW-1:0] cur_r, prev_r, hit_r;
  logic [NW-1:0] cur_idx;
  logic n_we, l_we;
  logic [NW-1:0] n_waddr, l_waddr;
  logic [PW-1:0] l_wdata;
  logic [31:0] nk_q, nt_q;
  logic [PW-1:0] nl_q;
  assign cur_idx = cur_r[NW-1:0];
  cht_ram #(.WIDTH(32), .DEPTH(NODE_SLOTS)) u_keys (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(key_r), .raddr(cur_idx), .rdata(nk_q));
  cht_ram #(.WIDTH(32), .DEPTH(NODE_SLOTS)) u_tags (
    .clk(clk), .we(n_we), .waddr(n_waddr), .wdata(tag_r), .raddr(cur_idx), .rdata(nt_q));
  cht_ram #(.WIDTH(PW), .DEPTH(NODE_SLOTS)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(cur_idx), .rdata(nl_q));

  logic slot_ok;
  assign slot_ok = (32'(slot_r) < 32'(NODE_SLOTS));
  assign n_we = cmd.add_wr;
  assign n_waddr = NW'(slot_r);

  // add: new node becomes bucket head; unlink: predecessor link or bucket head takes the matched node's link
  always_comb begin
    l_we = 1'b0;
    l_waddr = NW'(slot_r);
    l_wdata = head_cur;
    head_we = 1'b0;
    head_wdata = PW'(slot_r);
    if (cmd.add_wr) begin
      l_we = 1'b1;
      head_we = 1'b1;
    end else if (cmd.unlink) begin
      l_wdata = nl_q;
      if (prev_r == NIL) begin
        head_we = 1'b1;
        head_wdata = nl_q;
      end else begin
        l_we = 1'b1;
        l_waddr = prev_r[NW-1:0];
      end
    end
  end

  // match of the current node
  logic hit;
  always_comb begin
    unique case (cmd.mode)
      cht_pkg::MATCH_KEY:  hit = (nk_q == key_r);
      cht_pkg::MATCH_TAG:  hit = (nt_q == tag_r);
      cht_pkg::MATCH_BOTH: hit = (nk_q == key_r) && (nt_q == tag_r);
      default:             hit = 1'b0;
    endcase
  end

  // walk state; budget counts nodes this request may still visit
  logic [PW-1:0] budget_r;
  logic found_r;
  logic head_ld_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      budget_r <= PW'(NODE_SLOTS);
      found_r <= 1'b0;
      prev_r <= NIL;
      head_ld_r <= 1'b0;
    end else begin
      head_ld_r <= cmd.head_rd;
      if (head_ld_r) cur_r <= head_cur;
      if (cmd.node_adv || cmd.tag_to_key || cmd.set_hit) budget_r <= budget_r - PW'(1);
      if (cmd.node_adv) begin
        prev_r <= cur_r;
        cur_r <= nl_q;
      end
      if (cmd.tag_to_key) begin
        prev_r <= NIL;
        cur_r <= nl_q;
      end
      if (cmd.set_hit) begin
        found_r <= 1'b1;
        hit_r <= cur_r;
      end
      if (cmd.add_wr) begin
        found_r <= 1'b1;
        hit_r <= PW'(slot_r);
      end
    end
  end

  // result tag: add reports the tag written, walks the node's stored tag
  logic [31:0] hit_tag_r;
  always_ff @(posedge clk) begin
    if (cmd.set_hit) hit_tag_r <= nt_q;
    else if (cmd.add_wr) hit_tag_r <= tag_r;
  end

  assign sts.div_done = (dcnt_r == 6'd32);
  assign sts.cur_nil = (cur_r >= NIL);
  assign sts.budget_zero = (budget_r == '0);
  assign sts.hit = hit;
  assign sts.slot_ok = slot_ok;

  assign res_found = found_r;
  assign res_tag = found_r ? hit_tag_r : 32'd0;
  assign res_slot = found_r ? 8'(hit_r) : 8'd0;
endmodule
`default_nettype wire
